FILE: sv/ssm_pkg.sv
`timescale 1ns / 1ps

package ssm_pkg;

  localparam int unsigned STATUS_W = 11;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned DBC_W    = 5;
  localparam int unsigned STREAK_W = 4;

  localparam logic [CFG_W-1:0]    DEBOUNCE_LIMIT_RST = 4'd10;
  localparam logic [CFG_W-1:0]    ERROR_PERSIST_RST  = 4'd2;
  localparam logic [STREAK_W-1:0] STREAK_MAX         = 4'd15;

  // Status / pass bit positions
  localparam int unsigned BIT_SWITCH   = 10;
  localparam int unsigned BIT_TEMP     = 9;
  localparam int unsigned BIT_HW_TO    = 8;
  localparam int unsigned BIT_HW_EN    = 7;
  localparam int unsigned BIT_THERAPY  = 6;
  localparam int unsigned BIT_START    = 5;
  localparam int unsigned BIT_SRC_OK   = 4;
  localparam int unsigned BIT_HW_ERR   = 3;
  localparam int unsigned BIT_CUR_HIGH = 2;
  localparam int unsigned BIT_CUR_LOW  = 1;
  localparam int unsigned BIT_SW_TO    = 0;

  typedef enum logic {
    CFG_DEBOUNCE_LIMIT = 1'b0,
    CFG_ERROR_PERSIST  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic attach_switch;
    logic over_temp;
    logic hw_timeout;
    logic hw_enable;
    logic therapy_active;
    logic start_pin;
    logic source_fault_pin;
    logic hw_error;
    logic current_high;
    logic current_low;
    logic sw_timeout;
    logic led_expected_on;
  } sample_t;

  typedef struct packed {
    logic [DBC_W-1:0]    sw_settle_cnt;
    logic                stable_switch;
    logic [STREAK_W-1:0] error_streak;
  } mon_state_t;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_limit;
    logic [CFG_W-1:0] error_persist;
  } mon_cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status_word;
    logic [STATUS_W-1:0] pass_flags;
    logic                overall_pass;
  } result_t;

endpackage

FILE: sv/ssm_eval.sv
`timescale 1ns / 1ps

module ssm_eval
  import ssm_pkg::*;
(
  input  sample_t    sample,
  input  mon_state_t state_cur,
  input  mon_cfg_t   cfg,
  output mon_state_t state_nxt,
  output result_t    result
);

  logic [DBC_W-1:0]    dbc_inc;
  logic [STATUS_W-1:0] st;
  logic [STATUS_W-1:0] pass;
  logic [STATUS_W-1:0] req_mask;

  assign dbc_inc = state_cur.sw_settle_cnt + DBC_W'(1);

  // switch debounce and hw error streak
  always_comb begin
    state_nxt = state_cur;
    if (state_cur.sw_settle_cnt == '0) begin
      state_nxt.stable_switch = sample.attach_switch;
      state_nxt.sw_settle_cnt = DBC_W'(1);
    end else if (state_cur.stable_switch != sample.attach_switch) begin
      if (dbc_inc > {1'b0, cfg.debounce_limit}) begin
        state_nxt.stable_switch = sample.attach_switch;
        state_nxt.sw_settle_cnt = DBC_W'(1);
      end else begin
        state_nxt.sw_settle_cnt = dbc_inc;
      end
    end else begin
      state_nxt.sw_settle_cnt = DBC_W'(1);
    end

    if (sample.hw_error) begin
      if (state_cur.error_streak != STREAK_MAX) begin
        state_nxt.error_streak = state_cur.error_streak + STREAK_W'(1);
      end
    end else begin
      state_nxt.error_streak = '0;
    end
  end

  always_comb begin
    st = '0;
    st[BIT_SWITCH]   = state_nxt.stable_switch;
    st[BIT_TEMP]     = sample.over_temp;
    st[BIT_HW_TO]    = sample.hw_timeout;
    st[BIT_HW_EN]    = sample.hw_enable;
    st[BIT_THERAPY]  = sample.therapy_active;
    st[BIT_START]    = sample.start_pin;
    st[BIT_SRC_OK]   = ~sample.source_fault_pin;
    st[BIT_HW_ERR]   = sample.hw_error;
    st[BIT_CUR_HIGH] = sample.current_high;
    st[BIT_CUR_LOW]  = sample.current_low;
    st[BIT_SW_TO]    = sample.sw_timeout;

    pass = ~st;
    pass[BIT_SWITCH]  = st[BIT_SWITCH];
    pass[BIT_HW_EN]   = st[BIT_HW_EN];
    pass[BIT_THERAPY] = ~st[BIT_THERAPY] | sample.led_expected_on;
    pass[BIT_START]   = 1'b1;
    // error hidden until the streak reaches the persistence count
    pass[BIT_HW_ERR]  = ~sample.hw_error |
                        (state_nxt.error_streak < cfg.error_persist);

    req_mask = '1;
    req_mask[BIT_THERAPY] = sample.led_expected_on;

    result.status_word  = st;
    result.pass_flags   = pass;
    result.overall_pass = ((pass & req_mask) == req_mask);
  end

endmodule

FILE: sv/safety_status_monitor.sv
`timescale 1ns / 1ps

// Safety status monitor. Each item is one periodic sample of eleven fault
// pins plus led_expected_on; each item yields exactly one result: an 11-bit
// status word (bit 10 debounced attach switch ... bit 0 sw timeout, bit 4 is
// the inverted source-fault pin), per-bit pass flags in the same positions,
// and an overall pass that checks the therapy bit only while the LED is
// expected on. The first sample after reset sets the switch as is; later a
// change is adopted once debounce_limit differing samples in a row have
// been seen. A hw_error fails only once it has been seen error_persist
// samples in a row (streak saturates at 15). Two register stages: the
// sample is captured in an input register, then evaluated and written to
// the result register. Throughput is one item per clock while out_stall is
// low; out_valid rises when the item moves on into the result register.
// The input side keeps taking items while a result is stalled as long as
// the input register is free. Config registers: index 0 debounce_limit
// (reset 10), index 1 error_persist (reset 2); write only while the block
// is idle.

module safety_status_monitor
  import ssm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata,

  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_attach_switch,
  input  logic                in_over_temp,
  input  logic                in_hw_timeout,
  input  logic                in_hw_enable,
  input  logic                in_therapy_active,
  input  logic                in_start_pin,
  input  logic                in_source_fault_pin,
  input  logic                in_hw_error,
  input  logic                in_current_high,
  input  logic                in_current_low,
  input  logic                in_sw_timeout,
  input  logic                in_led_expected_on,

  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status_word,
  output logic [STATUS_W-1:0] out_pass_flags,
  output logic                out_overall_pass
);

  mon_cfg_t   cfg_r;
  mon_state_t state_r, state_nxt;
  sample_t    s1_sample_r;
  logic       s1_valid_r;
  logic       out_valid_r;
  result_t    res_r, res_nxt;
  logic       s1_move;   // input register hands its item to the evaluator
  logic       in_take;   // item accepted on the input channel

  // result register frees when empty or being drained
  assign s1_move  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_move;
  assign in_take  = in_valid && !in_stall;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_limit <= DEBOUNCE_LIMIT_RST;
      cfg_r.error_persist  <= ERROR_PERSIST_RST;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE_LIMIT: cfg_r.debounce_limit <= cfg_wdata;
        CFG_ERROR_PERSIST:  cfg_r.error_persist  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (s1_move) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_sample_r <= '{
        attach_switch:    in_attach_switch,
        over_temp:        in_over_temp,
        hw_timeout:       in_hw_timeout,
        hw_enable:        in_hw_enable,
        therapy_active:   in_therapy_active,
        start_pin:        in_start_pin,
        source_fault_pin: in_source_fault_pin,
        hw_error:         in_hw_error,
        current_high:     in_current_high,
        current_low:      in_current_low,
        sw_timeout:       in_sw_timeout,
        led_expected_on:  in_led_expected_on
      };
    end
  end

  ssm_eval u_eval (
    .sample    (s1_sample_r),
    .state_cur (state_r),
    .cfg       (cfg_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // monitor state advances exactly once per evaluated item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (s1_move) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_move) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status_word  = res_r.status_word;
  assign out_pass_flags   = res_r.pass_flags;
  assign out_overall_pass = res_r.overall_pass;

endmodule

FILE: sv/ssm_checker.sv
`timescale 1ns / 1ps

module ssm_checker
  import ssm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] out_status_word,
  input logic [STATUS_W-1:0] out_pass_flags,
  input logic                out_overall_pass
);

  // no result right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status_word) &&
      $stable(out_pass_flags) && $stable(out_overall_pass))
    else $error("stalled result changed");

  // source-fault bit is stored inverted and passes when it reads 0
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pass_flags[BIT_SRC_OK] == !out_status_word[BIT_SRC_OK] &&
      out_pass_flags[BIT_START])
    else $error("source fault or start pass flag wrong");

  // overall pass needs every flag except possibly therapy
  a_overall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overall_pass |->
      (out_pass_flags | (STATUS_W'(1) << BIT_THERAPY)) == '1)
    else $error("overall pass with a failing flag");

endmodule

bind safety_status_monitor ssm_checker u_ssm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_status_word  (out_status_word),
  .out_pass_flags   (out_pass_flags),
  .out_overall_pass (out_overall_pass)
);
